// File: sv/vrdf_pkg.sv
// Shared types, constants and helpers of the dual state machine vacuum robot controller.
`timescale 1ns / 1ps

package vrdf_pkg;

   // Width of the mode duration counter; it saturates at its all-ones value.
   localparam int COUNT_WIDTH = 8;
   // Width of every configuration register and of both countdowns.
   localparam int REG_W       = 8;
   // Width at which a duration is compared with a threshold.
   localparam int CMP_W       = (COUNT_WIDTH > REG_W) ? COUNT_WIDTH : REG_W;

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IDLE_START    = 3'd0,
      CSR_TURN          = 3'd1,
      CSR_BACKWARD      = 3'd2,
      CSR_PAUSE_RESUME  = 3'd3,
      CSR_PAUSE_TIMEOUT = 3'd4,
      CSR_TURBO         = 3'd5
   } csr_index_type;

   typedef enum logic [2:0] {
      M_IDLE    = 3'd0,
      M_MOVING  = 3'd1,
      M_TURNING = 3'd2,
      M_BACKING = 3'd3,
      M_PAUSED  = 3'd4
   } motor_mode_type;

   typedef enum logic [1:0] {
      C_OFF    = 2'd0,
      C_NORMAL = 2'd1,
      C_TURBO  = 2'd2
   } cleaner_mode_type;

   typedef enum logic [2:0] {
      MC_FORWARD  = 3'd0,
      MC_LEFT     = 3'd1,
      MC_RIGHT    = 3'd2,
      MC_BACKWARD = 3'd3,
      MC_STOP     = 3'd4
   } motor_cmd_type;

   typedef enum logic [1:0] {
      CC_OFF    = 2'd0,
      CC_NORMAL = 2'd1,
      CC_TURBO  = 2'd2
   } cleaner_cmd_type;

   typedef struct packed {
      logic front_blocked;
      logic left_blocked;
      logic right_blocked;
      logic dust_seen;
   } sensor_type;

   typedef struct packed {
      logic [REG_W-1:0] idle_start_ticks;
      logic [REG_W-1:0] turn_ticks;
      logic [REG_W-1:0] backward_ticks;
      logic [REG_W-1:0] pause_resume_ticks;
      logic [REG_W-1:0] pause_timeout_ticks;
      logic [REG_W-1:0] turbo_ticks;
   } cfg_type;

   typedef struct packed {
      motor_mode_type         motor_mode;
      cleaner_mode_type       cleaner_mode;
      motor_cmd_type          motor_cmd;
      cleaner_cmd_type        cleaner_cmd;
      logic [COUNT_WIDTH-1:0] duration;
      logic [REG_W-1:0]       backup_cd;
      logic [REG_W-1:0]       turbo_cd;
   } state_type;

   // True when a duration has reached a threshold.
   function automatic logic dur_reached(input logic [COUNT_WIDTH-1:0] dur,
                                        input logic [REG_W-1:0]       thr);
      logic [CMP_W-1:0] dur_w;
      logic [CMP_W-1:0] thr_w;
      dur_w = CMP_W'(dur);
      thr_w = CMP_W'(thr);
      return dur_w >= thr_w;
   endfunction

endpackage

// File: sv/vacuum_robot_dual_fsm_top.sv
// Top level of the vacuum robot controller: handshakes, configuration and state registers.
`timescale 1ns / 1ps
// A tick's result is registered onto rsp_tdata in the cycle after its beat is accepted.
// Throughput: one tick per cycle unless rsp_tready stalls; the next-state logic is a
// single pass over small registers; the result register frees whenever rsp_tready is high.
// Reset (synchronous, active high) restores the register defaults, puts the motor
// in idle with stop, the cleaner off, clears all counters and empties the result register.

module vacuum_robot_dual_fsm_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [0] front_blocked, [1] left_blocked, [2] right_blocked, [3] dust_seen, [7:4] zero
   input  logic [7:0]                      req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [2:0] motor_command, [4:3] cleaner_command, [7:5] motor_mode,
   // [9:8] cleaner_mode, [10] pause_request, [15:11] zero
   output logic [15:0]                     rsp_tdata,
   input  logic                            csr_we,
   input  logic [vrdf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vrdf_pkg::REG_W-1:0]      csr_wdata
);

   vrdf_pkg::cfg_type    cfg_ff;
   vrdf_pkg::state_type  state_ff;
   vrdf_pkg::state_type  state_in;
   vrdf_pkg::sensor_type sens;
   logic                 pause_request;
   logic                 req_accept;
   logic                 rsp_tvalid_ff;
   logic [15:0]          rsp_tdata_ff;
   logic [15:0]          rsp_tdata_in;

   // The result register takes a new beat when it is empty or being drained this cycle,
   // so a steady stream flows at one beat per cycle while rsp_tready stays high.
   assign req_tready = !rsp_tvalid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   assign sens.front_blocked = req_tdata[0];
   assign sens.left_blocked  = req_tdata[1];
   assign sens.right_blocked = req_tdata[2];
   assign sens.dust_seen     = req_tdata[3];

   // Both machines step together; the pause request and moving flag are taken from
   // the state as it stands before the tick.
   vrdf_step u_step (
      .cur           (state_ff),
      .cfg           (cfg_ff),
      .sens          (sens),
      .nxt           (state_in),
      .pause_request (pause_request)
   );

   // The modes reported are those after the tick; the pause request is the one sampled.
   assign rsp_tdata_in = {5'b0,
                          pause_request,
                          state_in.cleaner_mode,
                          state_in.motor_mode,
                          state_in.cleaner_cmd,
                          state_in.motor_cmd};

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_start_ticks    <= vrdf_pkg::REG_W'(2);
         cfg_ff.turn_ticks          <= vrdf_pkg::REG_W'(2);
         cfg_ff.backward_ticks      <= vrdf_pkg::REG_W'(3);
         cfg_ff.pause_resume_ticks  <= vrdf_pkg::REG_W'(1);
         cfg_ff.pause_timeout_ticks <= vrdf_pkg::REG_W'(5);
         cfg_ff.turbo_ticks         <= vrdf_pkg::REG_W'(5);
      end else if (csr_we) begin
         // Indexes beyond the register list are ignored.
         unique case (csr_index)
            vrdf_pkg::CSR_IDLE_START:    cfg_ff.idle_start_ticks    <= csr_wdata;
            vrdf_pkg::CSR_TURN:          cfg_ff.turn_ticks          <= csr_wdata;
            vrdf_pkg::CSR_BACKWARD:      cfg_ff.backward_ticks      <= csr_wdata;
            vrdf_pkg::CSR_PAUSE_RESUME:  cfg_ff.pause_resume_ticks  <= csr_wdata;
            vrdf_pkg::CSR_PAUSE_TIMEOUT: cfg_ff.pause_timeout_ticks <= csr_wdata;
            vrdf_pkg::CSR_TURBO:         cfg_ff.turbo_ticks         <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.motor_mode   <= vrdf_pkg::M_IDLE;
         state_ff.cleaner_mode <= vrdf_pkg::C_OFF;
         state_ff.motor_cmd    <= vrdf_pkg::MC_STOP;
         state_ff.cleaner_cmd  <= vrdf_pkg::CC_OFF;
         state_ff.duration     <= '0;
         state_ff.backup_cd    <= '0;
         state_ff.turbo_cd     <= '0;
         rsp_tvalid_ff         <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff <= state_in;
         end
         if (req_accept) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Result payload needs no reset; it is qualified by rsp_tvalid.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

endmodule

// File: sv/vrdf_step.sv
// Next state logic of the motor and cleaner machines for one control tick.
`timescale 1ns / 1ps

module vrdf_step (
   input  vrdf_pkg::state_type  cur,
   input  vrdf_pkg::cfg_type    cfg,
   input  vrdf_pkg::sensor_type sens,
   output vrdf_pkg::state_type  nxt,
   output logic                 pause_request
);

   logic                             moving;
   logic [vrdf_pkg::COUNT_WIDTH-1:0] dur_inc;

   always_comb begin
      pause_request = (cur.cleaner_mode == vrdf_pkg::C_TURBO);
      moving        = (cur.motor_mode == vrdf_pkg::M_MOVING);
      dur_inc       = (cur.duration == '1) ? cur.duration
                                           : cur.duration + vrdf_pkg::COUNT_WIDTH'(1);

      nxt          = cur;
      nxt.duration = dur_inc;

      // Motor machine; a mode change clears the duration.
      unique case (cur.motor_mode)
         vrdf_pkg::M_IDLE: begin
            nxt.motor_cmd = vrdf_pkg::MC_STOP;
            if (vrdf_pkg::dur_reached(dur_inc, cfg.idle_start_ticks)) begin
               nxt.motor_mode = vrdf_pkg::M_MOVING;
               nxt.duration   = '0;
            end
         end
         vrdf_pkg::M_MOVING: begin
            nxt.motor_cmd = vrdf_pkg::MC_FORWARD;
            if (pause_request) begin
               nxt.motor_mode = vrdf_pkg::M_PAUSED;
               nxt.duration   = '0;
            end else if (sens.front_blocked) begin
               nxt.motor_mode = vrdf_pkg::M_TURNING;
               nxt.duration   = '0;
            end
         end
         vrdf_pkg::M_TURNING: begin
            if (sens.front_blocked && sens.left_blocked && sens.right_blocked) begin
               nxt.motor_mode = vrdf_pkg::M_BACKING;
               nxt.duration   = '0;
               nxt.backup_cd  = cfg.backward_ticks;
            end else if (!sens.left_blocked || !sens.right_blocked) begin
               nxt.motor_cmd = !sens.left_blocked ? vrdf_pkg::MC_LEFT : vrdf_pkg::MC_RIGHT;
               if (vrdf_pkg::dur_reached(dur_inc, cfg.turn_ticks)) begin
                  nxt.motor_mode = vrdf_pkg::M_MOVING;
                  nxt.duration   = '0;
               end
            end else begin
               nxt.motor_mode = vrdf_pkg::M_PAUSED;
               nxt.duration   = '0;
            end
         end
         vrdf_pkg::M_BACKING: begin
            nxt.motor_cmd = vrdf_pkg::MC_BACKWARD;
            if (cur.backup_cd <= vrdf_pkg::REG_W'(1)) begin
               nxt.backup_cd  = '0;
               nxt.motor_mode = vrdf_pkg::M_TURNING;
               nxt.duration   = '0;
            end else begin
               nxt.backup_cd = cur.backup_cd - vrdf_pkg::REG_W'(1);
            end
         end
         default: begin
            // Paused, and any code outside the defined modes.
            nxt.motor_cmd = vrdf_pkg::MC_STOP;
            if (!pause_request && vrdf_pkg::dur_reached(dur_inc, cfg.pause_resume_ticks)) begin
               nxt.motor_mode = vrdf_pkg::M_MOVING;
               nxt.duration   = '0;
            end else if (vrdf_pkg::dur_reached(dur_inc, cfg.pause_timeout_ticks)) begin
               nxt.motor_mode = vrdf_pkg::M_BACKING;
               nxt.duration   = '0;
               nxt.backup_cd  = cfg.backward_ticks;
            end
         end
      endcase

      // Cleaner machine, using the moving flag sampled before the motor update.
      unique case (cur.cleaner_mode)
         vrdf_pkg::C_OFF: begin
            nxt.cleaner_cmd  = vrdf_pkg::CC_OFF;
            nxt.cleaner_mode = vrdf_pkg::C_NORMAL;
         end
         vrdf_pkg::C_NORMAL: begin
            nxt.cleaner_cmd = vrdf_pkg::CC_NORMAL;
            if (sens.dust_seen && moving) begin
               nxt.cleaner_mode = vrdf_pkg::C_TURBO;
               nxt.turbo_cd     = cfg.turbo_ticks;
            end
         end
         default: begin
            nxt.cleaner_cmd = vrdf_pkg::CC_TURBO;
            if (cur.turbo_cd <= vrdf_pkg::REG_W'(1)) begin
               nxt.turbo_cd     = '0;
               nxt.cleaner_mode = vrdf_pkg::C_NORMAL;
            end else begin
               nxt.turbo_cd = cur.turbo_cd - vrdf_pkg::REG_W'(1);
            end
         end
      endcase
   end

endmodule

// File: tb/tb_vacuum_robot_dual_fsm_top.sv
// Self-checking testbench for the vacuum robot dual state machine controller.
`timescale 1ns / 1ps

import vrdf_pkg::*;

// Fields of one result beat as packed on rsp_tdata, from the highest bit down.
typedef struct packed {
   logic [4:0]       pad;
   logic             pause_request;
   cleaner_mode_type cleaner_mode;
   motor_mode_type   motor_mode;
   cleaner_cmd_type  cleaner_cmd;
   motor_cmd_type    motor_cmd;
} tick_result_type;

// Tracks both state machines tick by tick and holds the results still owed by the block.
class robot_tick_scoreboard;
   logic [REG_W-1:0]       idle_start, turn_len, backward_len;
   logic [REG_W-1:0]       resume_len, timeout_len, turbo_len;
   motor_mode_type         motor_mode;
   cleaner_mode_type       cleaner_mode;
   motor_cmd_type          motor_cmd;
   cleaner_cmd_type        cleaner_cmd;
   logic [COUNT_WIDTH-1:0] duration;
   logic [REG_W-1:0]       backup_left, turbo_left;
   tick_result_type        owed[$];
   int                     mismatches;
   int                     compared;
   int                     mode_entries[5];

   function new();
      mismatches = 0;
      compared   = 0;
      foreach (mode_entries[i]) mode_entries[i] = 0;
      clear_state();
   endfunction

   function void clear_state();
      idle_start   = 8'd2;
      turn_len     = 8'd2;
      backward_len = 8'd3;
      resume_len   = 8'd1;
      timeout_len  = 8'd5;
      turbo_len    = 8'd5;
      motor_mode   = M_IDLE;
      cleaner_mode = C_OFF;
      motor_cmd    = MC_STOP;
      cleaner_cmd  = CC_OFF;
      duration     = '0;
      backup_left  = '0;
      turbo_left   = '0;
   endfunction

   function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [REG_W-1:0] value);
      case (index)
         CSR_IDLE_START:    idle_start   = value;
         CSR_TURN:          turn_len     = value;
         CSR_BACKWARD:      backward_len = value;
         CSR_PAUSE_RESUME:  resume_len   = value;
         CSR_PAUSE_TIMEOUT: timeout_len  = value;
         CSR_TURBO:         turbo_len    = value;
         default: ;
      endcase
   endfunction

   function void enter_mode(motor_mode_type m);
      motor_mode = m;
      duration   = '0;
      mode_entries[m]++;
   endfunction

   function void enter_backing();
      enter_mode(M_BACKING);
      backup_left = backward_len;
   endfunction

   function bit reached(logic [REG_W-1:0] threshold);
      return int'(duration) >= int'(threshold);
   endfunction

   function int pending();
      return owed.size();
   endfunction

   // Advances both machines by one accepted tick and queues the result it should give.
   function void note_tick(logic [3:0] sensors);
      logic            front, left, right, dust;
      logic            pause_q, moving_q;
      tick_result_type r;
      front    = sensors[0];
      left     = sensors[1];
      right    = sensors[2];
      dust     = sensors[3];
      pause_q  = (cleaner_mode == C_TURBO);
      moving_q = (motor_mode == M_MOVING);

      if (duration != '1) duration = duration + 1'b1;
      case (motor_mode)
         M_IDLE: begin
            motor_cmd = MC_STOP;
            if (reached(idle_start)) enter_mode(M_MOVING);
         end
         M_MOVING: begin
            motor_cmd = MC_FORWARD;
            if (pause_q) enter_mode(M_PAUSED);
            else if (front) enter_mode(M_TURNING);
         end
         M_TURNING: begin
            if (front && left && right) begin
               enter_backing();
            end else if (!left || !right) begin
               motor_cmd = !left ? MC_LEFT : MC_RIGHT;
               if (reached(turn_len)) enter_mode(M_MOVING);
            end else begin
               enter_mode(M_PAUSED);
            end
         end
         M_BACKING: begin
            motor_cmd = MC_BACKWARD;
            if (backup_left <= 1) begin
               backup_left = '0;
               enter_mode(M_TURNING);
            end else begin
               backup_left = backup_left - 1'b1;
            end
         end
         default: begin
            motor_cmd = MC_STOP;
            if (!pause_q && reached(resume_len)) enter_mode(M_MOVING);
            else if (reached(timeout_len)) enter_backing();
         end
      endcase

      case (cleaner_mode)
         C_OFF: begin
            cleaner_cmd  = CC_OFF;
            cleaner_mode = C_NORMAL;
         end
         C_NORMAL: begin
            cleaner_cmd = CC_NORMAL;
            if (dust && moving_q) begin
               cleaner_mode = C_TURBO;
               turbo_left   = turbo_len;
            end
         end
         default: begin
            cleaner_cmd = CC_TURBO;
            if (turbo_left <= 1) begin
               turbo_left   = '0;
               cleaner_mode = C_NORMAL;
            end else begin
               turbo_left = turbo_left - 1'b1;
            end
         end
      endcase

      r.pad           = '0;
      r.pause_request = pause_q;
      r.cleaner_mode  = cleaner_mode;
      r.motor_mode    = motor_mode;
      r.cleaner_cmd   = cleaner_cmd;
      r.motor_cmd     = motor_cmd;
      owed.push_back(r);
   endfunction

   function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         mismatches++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   // Compares one result beat with the oldest result still owed.
   function void check_result(logic [15:0] data);
      tick_result_type want;
      tick_result_type got;
      got = tick_result_type'(data);
      if (owed.size() == 0) begin
         mismatches++;
         $display("%0t ns: result beat %0h arrived with nothing expected", $time, data);
         return;
      end
      want = owed.pop_front();
      compared++;
      compare_field("motor_command",   8'(want.motor_cmd),     8'(got.motor_cmd));
      compare_field("cleaner_command", 8'(want.cleaner_cmd),   8'(got.cleaner_cmd));
      compare_field("motor_mode",      8'(want.motor_mode),    8'(got.motor_mode));
      compare_field("cleaner_mode",    8'(want.cleaner_mode),  8'(got.cleaner_mode));
      compare_field("pause_request",   8'(want.pause_request), 8'(got.pause_request));
      compare_field("padding",         8'(want.pad),           8'(got.pad));
   endfunction
endclass

module tb_vacuum_robot_dual_fsm_top;

   // Clock and the single reset at the start of the run.
   logic clock = 1'b0;
   logic reset = 1'b1;

   // Tick channel into the block: sensor bits in req_tdata[3:0], upper bits zero.
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = 8'h00;

   // Result channel out of the block.
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [15:0]            rsp_tdata;

   // Register write port.
   logic                   csr_we    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [REG_W-1:0]       csr_wdata = '0;

   robot_tick_scoreboard   board;
   int                     ticks_sent = 0;
   int                     settings   = 1;

   vacuum_robot_dual_fsm_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 10 ns period: rising edges at 5, 15, 25 ns and so on.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // A generous ceiling on the whole run; a correct run needs a small fraction of it,
   // even if every beat met the longest receiver stall.
   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   // The receiver moves between stretches of its own: always ready, randomly
   // stalling, and a rotating stall pattern. Each stretch lasts a random number
   // of cycles so that stalls land on every phase of the machines' work.
   int         stall_mode    = 0;
   int         stretch_left  = 0;
   logic [7:0] stall_pattern = 8'hFF;

   always @(negedge clock) begin
      if (stretch_left == 0) begin
         stall_mode    = $urandom_range(0, 2);
         stretch_left  = $urandom_range(8, 80);
         stall_pattern = 8'($urandom);
      end
      stretch_left = stretch_left - 1;
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 99) < 60);
         default: begin
            rsp_tready    <= stall_pattern[0];
            stall_pattern  = {stall_pattern[0], stall_pattern[7:1]};
         end
      endcase
   end

   // Every accepted result beat is checked against the oldest owed result.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
   end

   // Presents one tick and holds it until the block takes the beat.
   task automatic send_tick(input logic [3:0] sensors);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, sensors};
      do @(posedge clock); while (!req_tready);
      board.note_tick(sensors);
      ticks_sent++;
   endtask

   // Drops the tick valid for a number of cycles; zero leaves the stream unbroken.
   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= {4'b0000, 4'($urandom)};
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Waits until every owed result has come back, with the sender quiet.
   task automatic drain_results();
      pause_sender(1);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Writes one register; the predictor follows at the edge that does the write.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [REG_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      board.write_reg(index, value);
   endtask

   // Loads a full register setting, plus a write to an unused index that must
   // change nothing. Only called with no tick or result in flight.
   task automatic load_setting(input logic [REG_W-1:0] idle_v, input logic [REG_W-1:0] turn_v,
                               input logic [REG_W-1:0] back_v, input logic [REG_W-1:0] resume_v,
                               input logic [REG_W-1:0] timeout_v,
                               input logic [REG_W-1:0] turbo_v);
      write_reg(CSR_IDLE_START,    idle_v);
      write_reg(CSR_TURN,          turn_v);
      write_reg(CSR_BACKWARD,      back_v);
      write_reg(CSR_PAUSE_RESUME,  resume_v);
      write_reg(CSR_PAUSE_TIMEOUT, timeout_v);
      write_reg(3'($urandom_range(6, 7)), 8'($urandom));
      write_reg(CSR_TURBO,         turbo_v);
      @(negedge clock);
      csr_we <= 1'b0;
      settings++;
   endtask

   // Random ticks in bursts. Each sensor gets its own bias for the phase, so
   // some phases see many obstacles (turning and backing) and some much dust
   // (turbo, and with it pausing and the deadlock escape).
   task automatic run_random_ticks(input int count);
      int          bias[4];
      int          burst;
      int          sent;
      logic [3:0]  sensors;
      sent = 0;
      foreach (bias[i]) bias[i] = $urandom_range(15, 85);
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < count; k++) begin
            foreach (bias[i]) sensors[i] = ($urandom_range(0, 99) < bias[i]);
            send_tick(sensors);
            sent++;
         end
         if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 6));
      end
      drain_results();
   endtask

   // Directed ticks under the reset setting: start-up from idle, dust while
   // moving, each obstacle alone, all sides blocked, both sides blocked with
   // the front free, and the all-zero and all-one sensor words.
   logic [3:0] directed_ticks[23] = '{
      4'h0, 4'h0, 4'h0, 4'h9, 4'h1, 4'h7, 4'h0, 4'h0, 4'h0, 4'h7, 4'h6, 4'h6,
      4'h0, 4'h0, 4'h2, 4'h4, 4'hF, 4'hF, 4'h8, 4'h8, 4'h0, 4'h3, 4'h5
   };

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_ticks[i]) send_tick(directed_ticks[i]);
      drain_results();
      run_random_ticks(150);

      // All registers at zero: countdowns loaded with zero leave on the next tick.
      load_setting(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
      run_random_ticks(170);

      // All registers at their maximum: every threshold meets the saturated count.
      load_setting(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
      run_random_ticks(600);

      // Long turbo with a short timeout, so the pause ends in the deadlock escape.
      load_setting(8'd1, 8'd1, 8'd2, 8'd3, 8'd1, 8'd40);
      run_random_ticks(170);

      // Small random settings, where the machines change mode often.
      repeat (4) begin
         load_setting(8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                      8'($urandom_range(0, 6)), 8'($urandom_range(0, 6)),
                      8'($urandom_range(0, 8)), 8'($urandom_range(0, 12)));
         run_random_ticks(120);
      end

      // One setting drawn over the full range.
      load_setting(8'($urandom), 8'($urandom), 8'($urandom),
                   8'($urandom), 8'($urandom), 8'($urandom));
      run_random_ticks(60);

      // Nothing should still be owed; a few more cycles catch any stray beat.
      repeat (5) @(posedge clock);
      if (board.pending() != 0) begin
         board.mismatches++;
         $display("%0t ns: %0d results never arrived", $time, board.pending());
      end

      $display("Run covered %0d ticks under %0d register settings; %0d results compared.",
               ticks_sent, settings, board.compared);
      $display("Motor mode entries: moving %0d, turning %0d, backing %0d, paused %0d.",
               board.mode_entries[M_MOVING], board.mode_entries[M_TURNING],
               board.mode_entries[M_BACKING], board.mode_entries[M_PAUSED]);
      if (board.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
